>>> sv/ogru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogru_pkg: shared types, codes and helpers for the occupancy grid ray update
// Command codes, register indexes, controller states and the saturating
// cell update functions.
// ----------------------------------------------------------------------------
package ogru_pkg;

	localparam int GRID_WIDTH_DEF  = 512;
	localparam int GRID_HEIGHT_DEF = 512;

	localparam int COORD_W = 11;
	localparam int CELL_W  = 8;
	localparam int WALK_W  = 12;
	localparam int OCC_W   = 7;

	// command codes; the unused code acts as a read
	localparam logic [1:0] CMD_RAY  = 2'd0;
	localparam logic [1:0] CMD_MARK = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_FREE_STEP     = 2'd0;
	localparam logic [1:0] REG_OCCUPIED_STEP = 2'd1;
	localparam logic [1:0] REG_UPPER_LIMIT   = 2'd2;
	localparam logic [1:0] REG_LOWER_LIMIT   = 2'd3;

	localparam logic signed [4:0] FREE_STEP_RST     = -5'sd2;
	localparam logic [4:0]        OCCUPIED_STEP_RST = 5'd2;
	localparam logic [6:0]        UPPER_LIMIT_RST   = 7'd100;
	localparam logic signed [7:0] LOWER_LIMIT_RST   = -8'sd100;

	localparam logic [OCC_W-1:0] OCC_UNKNOWN = 7'd50;
	localparam logic [OCC_W-1:0] OCC_FULL    = 7'd100;
	localparam logic [12:0]      PCT_SCALE   = 13'd50;

	// |v|*50 <= 6400 fits 13 bits
	localparam int DIV_BITS = 13;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} cell_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_END_RD,
		ST_END_UPD,
		ST_SCALE,
		ST_DIV,
		ST_DONE
	} state_t;

	function automatic logic signed [7:0] fit8(input logic signed [9:0] t);
		logic signed [7:0] r;
		if (t < -10'sd128) begin
			r = -8'sd128;
		end else if (t > 10'sd127) begin
			r = 8'sd127;
		end else begin
			r = t[7:0];
		end
		return r;
	endfunction

	function automatic logic signed [7:0] free_upd(input logic signed [7:0] v,
			input logic signed [4:0] fs, input logic signed [7:0] ll);
		logic signed [9:0] t;
		logic signed [9:0] lo;
		t  = $signed({{2{v[7]}}, v}) + $signed({{5{fs[4]}}, fs});
		lo = $signed({{2{ll[7]}}, ll});
		if (t < lo) begin
			t = lo;
		end
		return fit8(t);
	endfunction

	function automatic logic signed [7:0] hit_upd(input logic signed [7:0] v,
			input logic [4:0] os, input logic [6:0] ul);
		logic signed [9:0] t;
		logic signed [9:0] hi;
		t  = $signed({{2{v[7]}}, v}) + $signed({5'b00000, os});
		hi = $signed({3'b000, ul});
		if (t > hi) begin
			t = hi;
		end
		return fit8(t);
	endfunction

endpackage

>>> sv/ogru_grid_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogru_grid_mem: log-odds cell store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ogru_grid_mem #(
	parameter int DEPTH = ogru_pkg::GRID_WIDTH_DEF * ogru_pkg::GRID_HEIGHT_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic signed [ogru_pkg::CELL_W-1:0] wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic signed [ogru_pkg::CELL_W-1:0] rdata
);

	logic signed [ogru_pkg::CELL_W-1:0] mem [DEPTH];
	logic signed [ogru_pkg::CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/ogru_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogru_walker: Bresenham line stepper
// Holds the current cell and error term, advances one cell per step.
// ----------------------------------------------------------------------------
module ogru_walker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            step,
	input  ogru_pkg::cell_t org,
	input  ogru_pkg::cell_t tgt,
	output ogru_pkg::cell_t cur,
	output logic            at_end
);

	ogru_pkg::cell_t    cur_q;
	logic signed [12:0] sx_q;
	logic signed [12:0] sy_q;
	logic signed [13:0] acc_q;
	logic               negx_q;
	logic               negy_q;

	logic signed [11:0] dx;
	logic signed [11:0] dy;
	logic [11:0]        adx;
	logic [11:0]        ady;
	logic signed [12:0] sx_ld;
	logic signed [12:0] sy_ld;
	logic signed [14:0] twice;
	logic               mx;
	logic               my;
	logic signed [13:0] acc_nx;

	always_comb begin
		dx    = $signed({tgt.x[10], tgt.x}) - $signed({org.x[10], org.x});
		dy    = $signed({tgt.y[10], tgt.y}) - $signed({org.y[10], org.y});
		adx   = dx[11] ? 12'(-dx) : 12'(dx);
		ady   = dy[11] ? 12'(-dy) : 12'(dy);
		sx_ld = $signed({1'b0, adx});
		sy_ld = 13'(-$signed({1'b0, ady}));

		twice  = $signed({acc_q, 1'b0});
		mx     = twice >= $signed({{2{sy_q[12]}}, sy_q});
		my     = twice <= $signed({{2{sx_q[12]}}, sx_q});
		acc_nx = acc_q
			+ (mx ? $signed({sy_q[12], sy_q}) : 14'sd0)
			+ (my ? $signed({sx_q[12], sx_q}) : 14'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			negx_q <= 1'b0;
			negy_q <= 1'b0;
		end else if (load) begin
			negx_q <= dx[11] || (dx == 12'sd0);
			negy_q <= dy[11] || (dy == 12'sd0);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= org;
			sx_q  <= sx_ld;
			sy_q  <= sy_ld;
			acc_q <= $signed({sx_ld[12], sx_ld}) + $signed({sy_ld[12], sy_ld});
		end else if (step) begin
			acc_q <= acc_nx;
			if (mx) begin
				cur_q.x <= cur_q.x + (negx_q ? -11'sd1 : 11'sd1);
			end
			if (my) begin
				cur_q.y <= cur_q.y + (negy_q ? -11'sd1 : 11'sd1);
			end
		end
	end

	assign cur    = cur_q;
	assign at_end = (cur_q.x == tgt.x) && (cur_q.y == tgt.y);

endmodule

>>> sv/ogru_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogru_div: radix-2 restoring divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module ogru_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ogru_pkg::DIV_BITS-1:0] dividend,
	input  logic [6:0]                    divisor,
	output logic [ogru_pkg::DIV_BITS-1:0] quotient,
	output logic                          done
);

	localparam int N  = ogru_pkg::DIV_BITS;
	localparam int CW = $clog2(N + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [6:0]    rem_q;
	logic [N-1:0]  quo_q;
	logic [7:0]    trial;
	logic          ge;

	assign trial = {rem_q, quo_q[N-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(N);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? 7'(trial - {1'b0, divisor}) : trial[6:0];
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

>>> sv/occupancy_grid_ray_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update: log-odds occupancy grid with Bresenham ray update
// Command channel: start is taken when busy is low. Ray, mark or read of the
// end cell; one result word per command, shown for one cycle with done.
// Configuration: cfg_we/cfg_index/cfg_data write a register at once.
// After reset the block sweeps all GRID_WIDTH*GRID_HEIGHT cells of the store to
// zero, one cell per cycle, with busy high; config writes still land.
// Sequence: a ray walks its cells one cell per cycle through the store's
// single read/write port pair (pipelined read-modify-write), then reads
// and updates the end cell; mark and read go straight to the end cell.
// The tail is the end-cell read/update plus a 13-step serial divide for
// the percent; an end cell outside the grid skips the divide.
// One command at a time: busy stays high until the done cycle has passed.
// done lasts exactly one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update #(
	parameter int GRID_WIDTH  = ogru_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = ogru_pkg::GRID_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [10:0] start_x,
	input  logic signed [10:0] start_y,
	input  logic signed [10:0] end_x,
	input  logic signed [10:0] end_y,
	output logic               done,
	output logic               status,
	output logic [6:0]         occupancy,
	output logic [11:0]        cells_walked,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	ogru_pkg::state_t state_q;
	ogru_pkg::state_t state_d;

	logic signed [4:0] free_step_q;
	logic [4:0]        occ_step_q;
	logic [6:0]        upper_q;
	logic signed [7:0] lower_q;

	logic [AW-1:0]     clr_q;
	logic              valid_s1;
	logic [AW-1:0]     addr_s1;

	logic [1:0]        cmd_q;
	ogru_pkg::cell_t   end_q;
	logic [11:0]       walked_q;
	logic              flag_q;
	logic              end_in_q;
	logic signed [7:0] val_q;
	logic [6:0]        occ_q;

	ogru_pkg::cell_t   port_org;
	ogru_pkg::cell_t   port_end;
	ogru_pkg::cell_t   tgt;
	ogru_pkg::cell_t   cur;
	logic              at_end;
	logic              accept;

	ogru_pkg::cell_t   sel;
	logic              sel_in;
	logic [AW-1:0]     sel_addr;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic signed [7:0] mem_wdata;
	logic              mem_re;
	logic signed [7:0] rdata;

	logic              is_update;
	logic signed [7:0] end_val;
	logic [7:0]        mag;
	logic [12:0]       dividend;
	logic [6:0]        divisor;
	logic              div_start;
	logic [12:0]       quo;
	logic              div_done;
	logic [6:0]        pct;

	assign port_org = '{x: start_x, y: start_y};
	assign port_end = '{x: end_x, y: end_y};
	assign accept   = (state_q == ogru_pkg::ST_IDLE) && start;
	assign tgt      = (state_q == ogru_pkg::ST_IDLE) ? port_end : end_q;

	ogru_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.step   ((state_q == ogru_pkg::ST_WALK) && !at_end),
		.org    (port_org),
		.tgt    (tgt),
		.cur    (cur),
		.at_end (at_end)
	);

	// one address unit shared by the walk and the end-cell access
	always_comb begin
		sel    = (state_q == ogru_pkg::ST_WALK) ? cur : end_q;
		sel_in = !sel.x[10] && ({1'b0, sel.x[9:0]} < 11'(GRID_WIDTH))
			&& !sel.y[10] && ({1'b0, sel.y[9:0]} < 11'(GRID_HEIGHT));
		sel_addr = AW'(AW'(sel.y[9:0]) * AW'(GRID_WIDTH) + AW'(sel.x[9:0]));
	end

	always_comb begin
		is_update = (cmd_q == ogru_pkg::CMD_RAY) || (cmd_q == ogru_pkg::CMD_MARK);
		end_val   = is_update ? ogru_pkg::hit_upd(rdata, occ_step_q, upper_q) : rdata;
		mag       = val_q[7] ? 8'(-val_q) : 8'(val_q);
		dividend  = 13'(mag) * ogru_pkg::PCT_SCALE;
		divisor   = (upper_q == 7'd0) ? 7'd1 : upper_q;
		if (val_q[7]) begin
			pct = (quo >= 13'(ogru_pkg::OCC_UNKNOWN)) ? 7'd0
				: 7'(13'(ogru_pkg::OCC_UNKNOWN) - quo);
		end else begin
			pct = (quo >= 13'(ogru_pkg::OCC_UNKNOWN)) ? ogru_pkg::OCC_FULL
				: 7'(13'(ogru_pkg::OCC_UNKNOWN) + quo);
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = ogru_pkg::free_upd(rdata, free_step_q, lower_q);
		div_start = 1'b0;
		if (valid_s1) begin
			mem_we = 1'b1;
		end
		unique case (state_q)
			ogru_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ogru_pkg::ST_IDLE;
				end
			end
			ogru_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (cmd == ogru_pkg::CMD_RAY) ? ogru_pkg::ST_WALK
						: ogru_pkg::ST_END_RD;
				end
			end
			ogru_pkg::ST_WALK: begin
				if (at_end) begin
					state_d = ogru_pkg::ST_END_RD;
				end else begin
					mem_re = sel_in;
				end
			end
			ogru_pkg::ST_END_RD: begin
				mem_re  = sel_in;
				state_d = ogru_pkg::ST_END_UPD;
			end
			ogru_pkg::ST_END_UPD: begin
				if (end_in_q && is_update) begin
					mem_we    = 1'b1;
					mem_waddr = sel_addr;
					mem_wdata = end_val;
				end
				state_d = end_in_q ? ogru_pkg::ST_SCALE : ogru_pkg::ST_DONE;
			end
			ogru_pkg::ST_SCALE: begin
				div_start = 1'b1;
				state_d   = ogru_pkg::ST_DIV;
			end
			ogru_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = ogru_pkg::ST_DONE;
				end
			end
			ogru_pkg::ST_DONE: begin
				state_d = ogru_pkg::ST_IDLE;
			end
			default: begin
				state_d = ogru_pkg::ST_IDLE;
			end
		endcase
	end

	ogru_grid_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (sel_addr),
		.rdata (rdata)
	);

	ogru_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ogru_pkg::ST_CLEAR;
			clr_q       <= '0;
			valid_s1    <= 1'b0;
			free_step_q <= ogru_pkg::FREE_STEP_RST;
			occ_step_q  <= ogru_pkg::OCCUPIED_STEP_RST;
			upper_q     <= ogru_pkg::UPPER_LIMIT_RST;
			lower_q     <= ogru_pkg::LOWER_LIMIT_RST;
		end else begin
			state_q  <= state_d;
			valid_s1 <= mem_re && (state_q == ogru_pkg::ST_WALK);
			if (state_q == ogru_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					ogru_pkg::REG_FREE_STEP:     free_step_q <= cfg_data[4:0];
					ogru_pkg::REG_OCCUPIED_STEP: occ_step_q  <= cfg_data[4:0];
					ogru_pkg::REG_UPPER_LIMIT:   upper_q     <= cfg_data[6:0];
					ogru_pkg::REG_LOWER_LIMIT:   lower_q     <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			end_q    <= port_end;
			walked_q <= 12'd1;
			flag_q   <= 1'b0;
		end
		if ((state_q == ogru_pkg::ST_WALK) && !at_end) begin
			walked_q <= walked_q + 12'd1;
			addr_s1  <= sel_addr;
			if (!sel_in) begin
				flag_q <= 1'b1;
			end
		end
		if (state_q == ogru_pkg::ST_END_RD) begin
			end_in_q <= sel_in;
			if (!sel_in) begin
				flag_q <= 1'b1;
			end
		end
		if (state_q == ogru_pkg::ST_END_UPD) begin
			val_q <= end_val;
			if (!end_in_q) begin
				occ_q <= ogru_pkg::OCC_UNKNOWN;
			end
		end
		if ((state_q == ogru_pkg::ST_DIV) && div_done) begin
			occ_q <= pct;
		end
	end

	assign busy         = (state_q != ogru_pkg::ST_IDLE);
	assign done         = (state_q == ogru_pkg::ST_DONE);
	assign status       = flag_q;
	assign occupancy    = occ_q;
	assign cells_walked = walked_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result word not a single-cycle strobe");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (occupancy <= ogru_pkg::OCC_FULL) && (cells_walked != 12'd0)
			&& (cells_walked <= 12'd2048))
		else $error("result word out of range");

	a_rmw_walk: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(state_q == ogru_pkg::ST_WALK))
		else $error("free-cell write outside a ray walk");

endmodule
